>>> design/rci_pkg.sv
// Package for the RSSI calibration interpolator: widths, command and status
// codes, item structs, table entry layout and the sequencer state type.
// No dependencies.
package rci_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W = 2;
    localparam int KEY_W  = 13;
    localparam int DBM_W  = 12;
    localparam int SU_W   = 4;
    localparam int STAT_W = 3;

    localparam int ENTRY_W = KEY_W + DBM_W + SU_W;
    localparam int DIFF_W  = DBM_W + 1;
    localparam int MUL_W   = KEY_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int DVD_W   = PROD_W;
    localparam int DCNT_W  = $clog2(DVD_W);

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_STORED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DROPPED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_CLEARED = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [KEY_W-1:0]        point_voltage;
        logic signed [DBM_W-1:0] point_dbm;
        logic [SU_W-1:0]         point_s_unit;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [KEY_W-1:0]        out_voltage;
        logic signed [DBM_W-1:0] out_dbm;
        logic [SU_W-1:0]         out_s_unit;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [DBM_W-1:0] dbm;
        logic [SU_W-1:0]         s_unit;
    } t_entry;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_SCAN   = 10'b00_0000_0010,
        ST_DRAIN  = 10'b00_0000_0100,
        ST_DECIDE = 10'b00_0000_1000,
        ST_MUL_A  = 10'b00_0001_0000,
        ST_MUL_B  = 10'b00_0010_0000,
        ST_ADD    = 10'b00_0100_0000,
        ST_DSTART = 10'b00_1000_0000,
        ST_DIV    = 10'b01_0000_0000,
        ST_RESULT = 10'b10_0000_0000
    } t_state;

endpackage

>>> design/rci_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> design/rci_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on rci_pkg.
module rci_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rci_pkg::DVD_W-1:0]  i_dividend,
    input  logic [rci_pkg::KEY_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rci_pkg::DVD_W-1:0]  o_quotient
);
    import rci_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [KEY_W-1:0]  r_div;

    logic [KEY_W:0]    w_trial;
    logic              w_fit;
    logic [KEY_W:0]    w_diff;
    logic              w_last;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_last  = r_busy && r_cnt == DCNT_W'(DVD_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            // remainder stays below the divisor, so the low bits suffice
            r_rem <= w_fit ? w_diff[KEY_W-1:0] : w_trial[KEY_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> design/rssi_calibration_interpolator.sv
// RSSI calibration interpolator: keyed calibration table plus query unit.
// Per item: clear and empty-table query go straight to the result; a load on
// an empty table writes without a scan, else it scans (one RAM read per entry,
// then the write); a query scans, then returns exact or clamped, or interpolates (28 quotient bits).
// One item in flight; a held output stalls. Reset (synchronous, active low)
// empties the table and drops any result.
module rssi_calibration_interpolator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rci_pkg::t_in   i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rci_pkg::t_out  o_out_item
);
    import rci_pkg::*;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;      // number of valid table entries
    logic              r_out_vld;

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    t_in               r_cmd;        // latched command item
    t_out              r_res;        // finished result waiting for output reg
    t_out              r_out;
    logic [IDX_W-1:0]  r_idx;        // scan read address
    logic [IDX_W-1:0]  r_rd_idx;     // index of data on the RAM output
    logic              r_pend;       // RAM output holds a scanned entry
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_has_lo;
    logic              r_has_hi;
    logic [KEY_W-1:0]  r_lo_key;
    logic [KEY_W-1:0]  r_hi_key;
    logic signed [DBM_W-1:0] r_lo_dbm;
    logic signed [DBM_W-1:0] r_hi_dbm;
    logic [SU_W-1:0]   r_lo_s;
    logic [SU_W-1:0]   r_hi_s;
    logic [KEY_W-1:0]  r_span;
    logic [KEY_W-1:0]  r_dv;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [NUM_W-1:0]  r_num;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_full;
    logic [IDX_W-1:0]  w_last;
    logic              w_is_load;
    t_entry            w_rd;
    t_entry            w_wr;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;

    logic [KEY_W-1:0]  w_elo_key;
    logic [KEY_W-1:0]  w_ehi_key;
    logic signed [DBM_W-1:0] w_elo_dbm;
    logic signed [DBM_W-1:0] w_ehi_dbm;
    logic [SU_W-1:0]   w_elo_s;
    logic              w_exact;

    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    logic signed [NUM_W-1:0]  w_num_neg;
    logic [DVD_W-1:0]  w_dividend;
    logic              w_div_start;
    logic              w_div_done;
    logic [DVD_W-1:0]  w_quo;
    logic signed [DBM_W-1:0] w_q_abs;
    logic signed [DBM_W-1:0] w_q_dbm;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_full     = r_count == CNT_W'(TABLE_DEPTH);
    assign w_last     = IDX_W'(r_count - CNT_W'(1));
    assign w_is_load  = r_cmd.mode == MODE_LOAD;

    // Clamp: a missing bracket side takes the other side's point.
    assign w_elo_key = r_has_lo ? r_lo_key : r_hi_key;
    assign w_elo_dbm = r_has_lo ? r_lo_dbm : r_hi_dbm;
    assign w_elo_s   = r_has_lo ? r_lo_s   : r_hi_s;
    assign w_ehi_key = r_has_hi ? r_hi_key : r_lo_key;
    assign w_ehi_dbm = r_has_hi ? r_hi_dbm : r_lo_dbm;
    assign w_exact   = w_elo_key == w_ehi_key;

    // ---------------------------------------------------------------
    // Calibration table
    // ---------------------------------------------------------------
    assign w_wr.key    = r_cmd.point_voltage;
    assign w_wr.dbm    = r_cmd.point_dbm;
    assign w_wr.s_unit = r_cmd.point_s_unit;
    assign w_we    = (r_state == ST_DECIDE) && w_is_load && (r_hit || !w_full);
    assign w_waddr = r_hit ? r_hit_idx : r_count[IDX_W-1:0];

    rci_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr),
        .i_raddr (r_idx),
        .o_rdata (w_rd)
    );

    // ---------------------------------------------------------------
    // Shared multiplier: lo_dbm * span, then diff * (v - lo)
    // ---------------------------------------------------------------
    always_comb begin
        if (r_state == ST_MUL_A) begin
            w_mul_a = MUL_W'(r_lo_dbm);
            w_mul_b = signed'({1'b0, r_span});
        end else begin
            w_mul_a = MUL_W'(r_diff);
            w_mul_b = signed'({1'b0, r_dv});
        end
    end
    assign w_prod = w_mul_a * w_mul_b;

    // ---------------------------------------------------------------
    // Division on magnitudes; sign restored after (truncation toward zero)
    // ---------------------------------------------------------------
    assign w_num_neg   = -r_num;
    assign w_dividend  = r_num[NUM_W-1] ? w_num_neg[DVD_W-1:0] : r_num[DVD_W-1:0];
    assign w_div_start = r_state == ST_DSTART;

    rci_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // quotient lies between the two bracket levels, so 12 bits hold it
    assign w_q_abs = signed'(w_quo[DBM_W-1:0]);
    assign w_q_dbm = r_num[NUM_W-1] ? -w_q_abs : w_q_abs;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_item.mode)
                        MODE_CLEAR: n_state = ST_RESULT;
                        MODE_LOAD:  n_state = (r_count == '0) ? ST_DECIDE : ST_SCAN;
                        MODE_QUERY: n_state = (r_count == '0) ? ST_RESULT : ST_SCAN;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:   if (r_idx == w_last) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = (w_is_load || w_exact) ? ST_RESULT : ST_MUL_A;
            ST_MUL_A:  n_state = ST_MUL_B;
            ST_MUL_B:  n_state = ST_ADD;
            ST_ADD:    n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DIV;
            ST_DIV:    if (w_div_done) n_state = ST_RESULT;
            ST_RESULT: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && i_in_item.mode == MODE_CLEAR) begin
                r_count <= '0;
            end else if (r_state == ST_DECIDE && w_is_load && !r_hit && !w_full) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_RESULT && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_pend   <= r_state == ST_SCAN;
        r_rd_idx <= r_idx;

        if (w_in_acc) begin
            r_cmd    <= i_in_item;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_has_lo <= 1'b0;
            r_has_hi <= 1'b0;
            if (i_in_item.mode == MODE_CLEAR) begin
                r_res <= '{STAT_CLEARED, '0, '0, '0};
            end else begin
                r_res <= '{STAT_EMPTY, i_in_item.point_voltage, '0, '0};
            end
        end

        if (r_state == ST_SCAN) begin
            r_idx <= r_idx + 1'b1;
        end

        // bracket search over the entry on the RAM output
        if (r_pend) begin
            if (w_rd.key == r_cmd.point_voltage) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
            end
            if (w_rd.key <= r_cmd.point_voltage && (!r_has_lo || w_rd.key > r_lo_key)) begin
                r_has_lo <= 1'b1;
                r_lo_key <= w_rd.key;
                r_lo_dbm <= w_rd.dbm;
                r_lo_s   <= w_rd.s_unit;
            end
            if (w_rd.key >= r_cmd.point_voltage && (!r_has_hi || w_rd.key < r_hi_key)) begin
                r_has_hi <= 1'b1;
                r_hi_key <= w_rd.key;
                r_hi_dbm <= w_rd.dbm;
                r_hi_s   <= w_rd.s_unit;
            end
        end

        if (r_state == ST_DECIDE) begin
            if (w_is_load) begin
                r_res <= '{(r_hit || !w_full) ? STAT_STORED : STAT_DROPPED,
                           r_cmd.point_voltage, r_cmd.point_dbm, r_cmd.point_s_unit};
            end else if (w_exact) begin
                r_res <= '{STAT_OK, w_elo_key, w_elo_dbm, w_elo_s};
            end
            r_span <= w_ehi_key - w_elo_key;
            r_dv   <= r_cmd.point_voltage - w_elo_key;
            r_diff <= DIFF_W'(w_ehi_dbm) - DIFF_W'(w_elo_dbm);
        end

        if (r_state == ST_MUL_A) begin
            r_prod <= w_prod;
        end
        if (r_state == ST_MUL_B) begin
            r_num  <= NUM_W'(r_prod);
            r_prod <= w_prod;
        end
        if (r_state == ST_ADD) begin
            r_num <= r_num + NUM_W'(r_prod);
        end

        if (r_state == ST_DIV && w_div_done) begin
            r_res <= '{STAT_OK, r_cmd.point_voltage, w_q_dbm, r_lo_s};
        end

        if (r_state == ST_RESULT && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("table count above depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_item.mode == MODE_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_span != '0))
        else $error("division started with zero span");

    a_no_write_full_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !r_hit) |-> !w_full)
        else $error("new point written into a full table");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && !w_out_free) |=> (r_state == ST_RESULT))
        else $error("result left while output register busy");

endmodule
